// ----- sv/hsf_pkg.sv -----
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants of the SLIP packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hsf_pkg;

    localparam int PAY_W  = 8;
    localparam int LEN_W  = 12;
    localparam int SEQ_W  = 3;
    localparam int CRC_W  = 16;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [PAY_W-1:0] FRAME_DELIM = 8'hC0;
    localparam logic [PAY_W-1:0] ESC_BYTE    = 8'hDB;
    localparam logic [PAY_W-1:0] ESC_DELIM   = 8'hDC;
    localparam logic [PAY_W-1:0] ESC_ESC     = 8'hDD;
    localparam logic [3:0]       HCI_TYPE    = 4'd14;
    localparam logic [CRC_W-1:0] CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY    = 16'h1021;

    // one unescaped line word handed from front to back
    typedef struct packed {
        logic [PAY_W-1:0] data;
        logic             esc;
        logic             run_end;
        logic             frame_end;
    } t_sym;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SOF,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_PAY,
        ST_CRCL,
        ST_CRCH,
        ST_EOF
    } t_step;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_bk;

endpackage

`default_nettype wire

// ----- sv/hsf_ifs.sv -----
// ----------------------------------------------------------------------------
// hsf_ifs
// Valid/ready channels of the SLIP packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsf_in_if;
    import hsf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PAY_W-1:0] payload_byte;
    logic [LEN_W-1:0] packet_length;
    logic             last_byte;

    modport source(output valid, payload_byte, packet_length, last_byte, input ready);
    modport sink(input valid, payload_byte, packet_length, last_byte, output ready);
endinterface

interface hsf_out_if;
    import hsf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PAY_W-1:0] line_byte;
    logic             run_end;
    logic             frame_end;

    modport source(output valid, line_byte, run_end, frame_end, input ready);
    modport sink(input valid, line_byte, run_end, frame_end, output ready);
endinterface

`default_nettype wire

// ----- sv/hci_slip_packet_framer.sv -----
// ----------------------------------------------------------------------------
// hci_slip_packet_framer
// Three-wire UART packet framer: header, SLIP escaping and CRC-16 trailer.
// ----------------------------------------------------------------------------
// Throughput: front emits one unescaped word per cycle unless the queue is
//   full (a first word adds SOF and four header words, a last word two CRC
//   words and EOF); each 0xC0/0xDB goes out as a two-word escape pair; the
//   output port moves one word a cycle while the receiver is ready.
// Reset: synchronous, active low; sequence count 0, CRC 0xFFFF, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_slip_packet_framer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hsf_in_if.sink    i_in,
    hsf_out_if.source o_out
);
    import hsf_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_sym w_sym;
    t_sym w_head;

    hsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_sym   (w_sym)
    );

    hsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_sym   (w_sym),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    hsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- sv/hsf_front.sv -----
// ----------------------------------------------------------------------------
// hsf_front
// Accepts payload words, builds header and CRC, and pushes one unescaped
// line word per cycle into the queue while it is not full.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hsf_in_if.sink             i_in,
    input  wire logic          i_full,
    output logic               o_push,
    output hsf_pkg::t_sym      o_sym
);
    import hsf_pkg::*;

    function automatic logic [CRC_W-1:0] f_crc(input logic [CRC_W-1:0] c,
                                               input logic [PAY_W-1:0] b);
        logic [CRC_W-1:0] x;
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            x = x[CRC_W-1] ? ({x[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {x[CRC_W-2:0], 1'b0};
        end
        return x;
    endfunction

    t_step            r_step, n_step;
    logic [PAY_W-1:0] r_pay;
    logic [LEN_W-1:0] r_len;
    logic             r_last;
    logic [SEQ_W-1:0] r_seq;
    logic [CRC_W-1:0] r_crc;
    logic             r_inside, n_inside;

    logic             w_final;
    logic             w_feed;
    logic             w_accept;
    logic [SEQ_W-1:0] w_nxt;
    logic [PAY_W-1:0] w_h0, w_h1, w_h2, w_h3;

    assign w_nxt = r_seq + 1'b1;
    assign w_h0  = {1'b1, 1'b1, w_nxt, r_seq};
    assign w_h1  = {r_len[3:0], HCI_TYPE};
    assign w_h2  = r_len[LEN_W-1:4];
    assign w_h3  = 8'(8'd0 - w_h0 - w_h1 - w_h2);

    assign o_push     = (r_step != ST_IDLE) && !i_full;
    assign i_in.ready = (r_step == ST_IDLE) || (o_push && w_final);
    assign w_accept   = i_in.valid && i_in.ready;

    // outputs
    always_comb begin
        o_sym   = '0;
        w_final = 1'b0;
        w_feed  = 1'b0;
        unique case (r_step)
            ST_IDLE: ;
            ST_SOF:  o_sym.data = FRAME_DELIM;
            ST_H0: begin
                o_sym.data = w_h0; o_sym.esc = 1'b1; w_feed = 1'b1;
            end
            ST_H1: begin
                o_sym.data = w_h1; o_sym.esc = 1'b1; w_feed = 1'b1;
            end
            ST_H2: begin
                o_sym.data = w_h2; o_sym.esc = 1'b1; w_feed = 1'b1;
            end
            ST_H3: begin
                o_sym.data = w_h3; o_sym.esc = 1'b1; w_feed = 1'b1;
            end
            ST_PAY: begin
                o_sym.data = r_pay; o_sym.esc = 1'b1; w_feed = 1'b1;
                w_final    = !r_last;
            end
            ST_CRCL: begin
                o_sym.data = r_crc[7:0]; o_sym.esc = 1'b1;
            end
            ST_CRCH: begin
                o_sym.data = r_crc[15:8]; o_sym.esc = 1'b1;
            end
            ST_EOF: begin
                o_sym.data      = FRAME_DELIM;
                o_sym.frame_end = 1'b1;
                w_final         = 1'b1;
            end
            default: ;
        endcase
        o_sym.run_end = w_final;
    end

    always_comb begin
        n_inside = r_inside;
        if (o_push && r_step == ST_SOF) begin
            n_inside = 1'b1;
        end else if (o_push && r_step == ST_EOF) begin
            n_inside = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_step = r_step;
        if (r_step == ST_IDLE || (o_push && w_final)) begin
            if (w_accept) begin
                n_step = n_inside ? ST_PAY : ST_SOF;
            end else begin
                n_step = ST_IDLE;
            end
        end else if (o_push) begin
            unique case (r_step)
                ST_SOF:  n_step = ST_H0;
                ST_H0:   n_step = ST_H1;
                ST_H1:   n_step = ST_H2;
                ST_H2:   n_step = ST_H3;
                ST_H3:   n_step = ST_PAY;
                ST_PAY:  n_step = ST_CRCL;
                ST_CRCL: n_step = ST_CRCH;
                ST_CRCH: n_step = ST_EOF;
                default: n_step = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_IDLE;
            r_seq    <= '0;
            r_crc    <= CRC_INIT;
            r_inside <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_inside <= n_inside;
            if (o_push && r_step == ST_SOF) begin
                r_seq <= w_nxt;
                r_crc <= CRC_INIT;
            end else if (o_push && r_step == ST_EOF) begin
                r_crc <= CRC_INIT;
            end else if (o_push && w_feed) begin
                r_crc <= f_crc(r_crc, o_sym.data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pay  <= i_in.payload_byte;
            r_len  <= i_in.packet_length;
            r_last <= i_in.last_byte;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hsf_fifo.sv -----
// ----------------------------------------------------------------------------
// hsf_fifo
// Short word queue between the framing front and the escaping back.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hsf_pkg::t_sym i_sym,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output hsf_pkg::t_sym      o_head
);
    import hsf_pkg::*;

    t_sym           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_sym;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hsf_back.sv -----
// ----------------------------------------------------------------------------
// hsf_back
// Escapes queued words onto the line through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire hsf_pkg::t_sym i_head,
    output logic               o_pop,
    hsf_out_if.source          o_out
);
    import hsf_pkg::*;

    t_bk              r_bs, n_bs;
    logic             r_valid, n_valid;
    logic [PAY_W-1:0] r_byte, n_byte;
    logic             r_run, n_run;
    logic             r_frame, n_frame;
    logic             w_load;
    logic             w_special;

    assign w_load    = !r_valid || o_out.ready;
    assign w_special = i_head.esc &&
                       (i_head.data == FRAME_DELIM || i_head.data == ESC_BYTE);

    // next state
    always_comb begin
        n_bs = r_bs;
        unique case (r_bs)
            BK_FIRST:  if (w_load && !i_empty && w_special) n_bs = BK_SECOND;
            BK_SECOND: if (w_load) n_bs = BK_FIRST;
            default:   n_bs = BK_FIRST;
        endcase
    end

    // outputs
    always_comb begin
        n_valid = r_valid && !o_out.ready;
        n_byte  = r_byte;
        n_run   = r_run;
        n_frame = r_frame;
        o_pop   = 1'b0;
        unique case (r_bs)
            BK_FIRST: begin
                if (w_load && !i_empty) begin
                    n_valid = 1'b1;
                    if (w_special) begin
                        n_byte  = ESC_BYTE;
                        n_run   = 1'b0;
                        n_frame = 1'b0;
                    end else begin
                        n_byte  = i_head.data;
                        n_run   = i_head.run_end;
                        n_frame = i_head.frame_end;
                        o_pop   = 1'b1;
                    end
                end
            end
            BK_SECOND: begin
                if (w_load) begin
                    n_valid = 1'b1;
                    n_byte  = (i_head.data == FRAME_DELIM) ? ESC_DELIM : ESC_ESC;
                    n_run   = i_head.run_end;
                    n_frame = i_head.frame_end;
                    o_pop   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs    <= BK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_bs    <= n_bs;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_run   <= n_run;
        r_frame <= n_frame;
    end

    assign o_out.valid     = r_valid;
    assign o_out.line_byte = r_byte;
    assign o_out.run_end   = r_run;
    assign o_out.frame_end = r_frame;

    a_esc_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.line_byte == ESC_BYTE)
        |=> (o_out.valid && (o_out.line_byte == ESC_DELIM || o_out.line_byte == ESC_ESC)))
        else $error("escape prefix not followed by escape code");

    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end)
        |-> (o_out.run_end && o_out.line_byte == FRAME_DELIM))
        else $error("frame end on a word other than a closing delimiter");

    a_second_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs == BK_SECOND) |-> (!i_empty && w_special))
        else $error("escape second half without a pending special word");

endmodule

`default_nettype wire

// ----- verif/hci_slip_packet_framer_test.sv -----
// ----------------------------------------------------------------------------
// hci_slip_packet_framer_test
// Stand-alone check of the SLIP packet framer. Payload words go in through a
// valid/ready channel. A framing predictor builds the escaped line words that
// each accepted word should cause. Every line word that comes out is compared
// with the oldest predicted one. Covered: directed extremes, random packets
// under three idle patterns, and a long output stall that fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module hci_slip_packet_framer_test;
    import hsf_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [PAY_W-1:0] line_byte;
        logic             run_end;
        logic             frame_end;
    } t_line_word;

    logic i_clk;
    logic i_rst_n;

    hsf_in_if  in_ch ();
    hsf_out_if out_ch ();

    hci_slip_packet_framer i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // predictor state
    logic [SEQ_W-1:0] seq_count;
    logic [CRC_W-1:0] frame_crc;
    logic             pkt_open;
    t_line_word       line_words_due[$];

    int mismatch_count;
    int words_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;
    int quiet_cycles;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [CRC_W-1:0] crc_ccitt_byte(input logic [CRC_W-1:0] crc_in,
                                                        input logic [PAY_W-1:0] data);
        logic [CRC_W-1:0] r;
        int k;
        r = crc_in ^ {data, 8'h00};
        for (k = 0; k < 8; k++) begin
            if (r[CRC_W-1]) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    task automatic push_line(input logic [PAY_W-1:0] data, input logic at_frame_end);
        t_line_word w;
        w.line_byte = data;
        w.run_end   = 1'b0;
        w.frame_end = at_frame_end;
        line_words_due.push_back(w);
    endtask

    task automatic push_escaped(input logic [PAY_W-1:0] data);
        if (data == FRAME_DELIM) begin
            push_line(ESC_BYTE, 1'b0);
            push_line(ESC_DELIM, 1'b0);
        end else if (data == ESC_BYTE) begin
            push_line(ESC_BYTE, 1'b0);
            push_line(ESC_ESC, 1'b0);
        end else begin
            push_line(data, 1'b0);
        end
    endtask

    // line words caused by one accepted payload word
    task automatic frame_payload_word(input logic [PAY_W-1:0] pay,
                                      input logic [LEN_W-1:0] len,
                                      input logic last);
        logic [PAY_W-1:0] hdr[4];
        logic [SEQ_W-1:0] nxt;
        logic [PAY_W-1:0] sum;
        int i;
        if (!pkt_open) begin
            seq_count = seq_count + 1'b1;
            nxt       = seq_count + 1'b1;
            hdr[0]    = {2'b11, nxt, seq_count};
            hdr[1]    = {len[3:0], HCI_TYPE};
            hdr[2]    = len[11:4];
            sum       = hdr[0] + hdr[1] + hdr[2];
            hdr[3]    = ~sum + 8'd1;
            frame_crc = CRC_INIT;
            push_line(FRAME_DELIM, 1'b0);
            for (i = 0; i < 4; i++) begin
                frame_crc = crc_ccitt_byte(frame_crc, hdr[i]);
                push_escaped(hdr[i]);
            end
            pkt_open = 1'b1;
        end
        frame_crc = crc_ccitt_byte(frame_crc, pay);
        push_escaped(pay);
        if (last) begin
            push_escaped(frame_crc[7:0]);
            push_escaped(frame_crc[15:8]);
            push_line(FRAME_DELIM, 1'b1);
            frame_crc = CRC_INIT;
            pkt_open  = 1'b0;
        end
        line_words_due[line_words_due.size()-1].run_end = 1'b1;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [PAY_W-1:0] pay,
                             input logic [LEN_W-1:0] len,
                             input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.payload_byte  <= pay;
        in_ch.packet_length <= len;
        in_ch.last_byte     <= last;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        frame_payload_word(pay, len, last);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic test_directed_extremes();
        send_word(8'h00, 12'd1, 1'b1);
        send_word(8'hFF, 12'd4095, 1'b1);
        send_word(FRAME_DELIM, 12'd1, 1'b1);
        send_word(ESC_BYTE, 12'd1, 1'b1);
        send_word(ESC_DELIM, 12'd1, 1'b1);
        send_word(ESC_ESC, 12'd1, 1'b1);
        // zero length
        send_word(8'h5A, 12'd0, 1'b1);
        // header length bytes that need escaping
        send_word(8'h11, 12'hC00, 1'b1);
        send_word(8'h22, 12'hDB0, 1'b1);
        // declared longer than sent
        send_word(8'h01, 12'd5, 1'b0);
        send_word(FRAME_DELIM, 12'd0, 1'b1);
        // declared shorter than sent
        send_word(ESC_BYTE, 12'd1, 1'b0);
        send_word(FRAME_DELIM, 12'hFFF, 1'b0);
        send_word(8'hAA, 12'd0, 1'b0);
        send_word(8'h55, 12'd7, 1'b1);
        // well-formed four-word packet
        send_word(8'h80, 12'd4, 1'b0);
        send_word(8'h7F, 12'd4, 1'b0);
        send_word(8'hFF, 12'd4, 1'b0);
        send_word(8'h00, 12'd4, 1'b1);
    endtask

    function automatic logic [PAY_W-1:0] rand_payload();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            return FRAME_DELIM;
        end else if (pick < 24) begin
            return ESC_BYTE;
        end
        return PAY_W'($urandom_range(255));
    endfunction

    task automatic test_random_packets(input int n_words);
        int target;
        int n_bytes;
        int b;
        logic [LEN_W-1:0] len_field;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(9) == 0) begin
                n_bytes = $urandom_range(1, 40);
            end else begin
                n_bytes = $urandom_range(1, 10);
            end
            if ($urandom_range(3) != 0) begin
                len_field = LEN_W'(n_bytes);
            end else begin
                len_field = LEN_W'($urandom_range(4095));
            end
            for (b = 0; b < n_bytes; b++) begin
                // length is only sampled on the first word
                send_word(rand_payload(), (b == 0) ? len_field : LEN_W'($urandom_range(4095)),
                          b == n_bytes - 1);
            end
        end
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        test_random_packets(50);
    endtask

    // receiver
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // line word checker
    always @(posedge i_clk) begin
        t_line_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (line_words_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word: byte %h run_end %b frame_end %b", $time,
                         out_ch.line_byte, out_ch.run_end, out_ch.frame_end);
            end else begin
                want = line_words_due.pop_front();
                if (out_ch.line_byte !== want.line_byte || out_ch.run_end !== want.run_end ||
                    out_ch.frame_end !== want.frame_end) begin
                    mismatch_count++;
                    $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b", $time,
                             want.line_byte, want.run_end, want.frame_end,
                             out_ch.line_byte, out_ch.run_end, out_ch.frame_end);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.payload_byte  = '0;
        in_ch.packet_length = '0;
        in_ch.last_byte     = 1'b0;
        seq_count           = '0;
        frame_crc           = CRC_INIT;
        pkt_open            = 1'b0;
        mismatch_count      = 0;
        words_sent          = 0;
        hold_left           = 0;
        hold_req            = 1'b0;
        send_idle_pct       = 11;
        recv_idle_pct       = 47;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_extremes();
        test_random_packets(150);

        send_idle_pct = 47;
        recv_idle_pct = 11;
        test_random_packets(150);
        test_output_stall();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_packets(130);

        in_ch.valid <= 1'b0;
        while (line_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && line_words_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
